// ===== rtl/knn_pkg.sv =====
package knn_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_NEIGHBOURS_DEF = 32;
   localparam int COORD_BITS_DEF     = 24;
   localparam int INDEX_BITS_DEF     = 16;

   // Neighbour count register
   localparam int                     NCOUNT_BITS  = 6;
   localparam logic [NCOUNT_BITS-1:0] NCOUNT_RESET = 6'd8;

   // Register map
   localparam int                       CSR_ADDR_BITS = 2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_QUERY_X   = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_QUERY_Y   = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_QUERY_Z   = 2'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_NCOUNT    = 2'd3;

   // Result fields
   localparam int          RSP_INDEX_BITS = 16;
   localparam int          RSP_DIST_BITS  = 48;
   localparam int          RSP_RANK_BITS  = 5;
   localparam logic [63:0] DIST_OUT_MAX   = 64'd211106232532992;

   // Queue between the distance pipe and the selection engine
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

endpackage

// ===== rtl/knn_ram.sv =====
module knn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/knn_front.sv =====
module knn_front
   import knn_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int INDEX_BITS = INDEX_BITS_DEF,
   localparam int DIST_BITS = 2 * COORD_BITS + 2,
   localparam int ITEM_BITS = DIST_BITS + INDEX_BITS + 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [COORD_BITS-1:0]  pt_x,
   input  logic [COORD_BITS-1:0]  pt_y,
   input  logic [COORD_BITS-1:0]  pt_z,
   input  logic [INDEX_BITS-1:0]  pt_index,
   input  logic                   pt_last,
   input  logic [COORD_BITS-1:0]  query_x,
   input  logic [COORD_BITS-1:0]  query_y,
   input  logic [COORD_BITS-1:0]  query_z,
   input  logic [QCOUNT_BITS-1:0] q_count,
   output logic                   push,
   output logic [ITEM_BITS-1:0]   push_data
);

   logic                         v1_ff, v1_in, v2_ff;
   logic signed [COORD_BITS:0]   dx_ff, dy_ff, dz_ff, dx_in, dy_in, dz_in;
   logic [INDEX_BITS-1:0]        idx1_ff, idx2_ff;
   logic                         last1_ff, last2_ff;
   logic signed [2*COORD_BITS+1:0] px, py, pz;
   logic [2*COORD_BITS-1:0]      sx_ff, sy_ff, sz_ff;
   logic [QCOUNT_BITS:0]         pending;
   logic [DIST_BITS-1:0]         dist_sum;

   // Credit: everything in flight must fit in the queue
   assign pending  = (QCOUNT_BITS+1)'(v1_ff) + (QCOUNT_BITS+1)'(v2_ff)
                   + (QCOUNT_BITS+1)'(q_count);
   assign in_ready = pending < (QCOUNT_BITS+1)'(QUEUE_DEPTH);
   assign v1_in    = in_valid && in_ready;

   assign dx_in = $signed({pt_x[COORD_BITS-1], pt_x}) - $signed({query_x[COORD_BITS-1], query_x});
   assign dy_in = $signed({pt_y[COORD_BITS-1], pt_y}) - $signed({query_y[COORD_BITS-1], query_y});
   assign dz_in = $signed({pt_z[COORD_BITS-1], pt_z}) - $signed({query_z[COORD_BITS-1], query_z});

   // Squares are non-negative and below 2^(2*COORD_BITS)
   assign px = (2*COORD_BITS+2)'(dx_ff) * (2*COORD_BITS+2)'(dx_ff);
   assign py = (2*COORD_BITS+2)'(dy_ff) * (2*COORD_BITS+2)'(dy_ff);
   assign pz = (2*COORD_BITS+2)'(dz_ff) * (2*COORD_BITS+2)'(dz_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      dz_ff    <= dz_in;
      idx1_ff  <= pt_index;
      last1_ff <= pt_last;
      sx_ff    <= px[2*COORD_BITS-1:0];
      sy_ff    <= py[2*COORD_BITS-1:0];
      sz_ff    <= pz[2*COORD_BITS-1:0];
      idx2_ff  <= idx1_ff;
      last2_ff <= last1_ff;
   end

   assign dist_sum  = DIST_BITS'(sx_ff) + DIST_BITS'(sy_ff) + DIST_BITS'(sz_ff);
   assign push      = v2_ff;
   assign push_data = {last2_ff, idx2_ff, dist_sum};

endmodule

// ===== rtl/knn_queue.sv =====
module knn_queue
   import knn_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic [WIDTH-1:0]       push_data,
   input  logic                   pop,
   output logic [WIDTH-1:0]       head_data,
   output logic                   empty,
   output logic [QCOUNT_BITS-1:0] count
);

   logic [WIDTH-1:0]          entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCOUNT_BITS-1:0]    count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data = entry_ff[rd_ptr_ff];
   assign empty     = (count_ff == '0);
   assign count     = count_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < QCOUNT_BITS'(QUEUE_DEPTH)))
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("queue pop while empty");

endmodule

// ===== rtl/knn_back.sv =====
module knn_back
   import knn_pkg::*;
#(
   parameter int MAX_NEIGHBOURS = MAX_NEIGHBOURS_DEF,
   parameter int COORD_BITS     = COORD_BITS_DEF,
   parameter int INDEX_BITS     = INDEX_BITS_DEF,
   localparam int DIST_BITS = 2 * COORD_BITS + 2,
   localparam int ITEM_BITS = DIST_BITS + INDEX_BITS + 1,
   localparam int K_BITS    = $clog2(MAX_NEIGHBOURS + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_empty,
   input  logic [ITEM_BITS-1:0]      q_data,
   output logic                      q_pop,
   input  logic [K_BITS-1:0]         k,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [RSP_INDEX_BITS-1:0] rsp_index,
   output logic [RSP_DIST_BITS-1:0]  rsp_dist,
   output logic [RSP_RANK_BITS-1:0]  rsp_rank,
   output logic                      rsp_last
);

   localparam int ENTRY_BITS = DIST_BITS + INDEX_BITS;
   localparam int SLOT_BITS  = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DRAIN  = 3'd2;
   localparam logic [2:0] ST_DECIDE = 3'd3;
   localparam logic [2:0] ST_PICK   = 3'd4;

   logic [2:0]                state_ff, state_in;
   logic                      emit_ff, emit_in;
   logic [SLOT_BITS-1:0]      ptr_ff, ptr_in;
   logic                      chk_v_ff, chk_v_in;
   logic [SLOT_BITS-1:0]      chk_slot_ff, chk_slot_in;
   logic [DIST_BITS-1:0]      cur_dist_ff, cur_dist_in;
   logic [INDEX_BITS-1:0]     cur_idx_ff, cur_idx_in;
   logic                      cur_last_ff, cur_last_in;
   logic [DIST_BITS-1:0]      best_dist_ff, best_dist_in;
   logic [INDEX_BITS-1:0]     best_idx_ff, best_idx_in;
   logic [SLOT_BITS-1:0]      best_slot_ff, best_slot_in;
   logic                      best_v_ff, best_v_in;
   logic                      empty_found_ff, empty_found_in;
   logic [SLOT_BITS-1:0]      empty_slot_ff, empty_slot_in;
   logic [K_BITS-1:0]         cand_cnt_ff, cand_cnt_in;
   logic [MAX_NEIGHBOURS-1:0] valid_ff, valid_in;
   logic [MAX_NEIGHBOURS-1:0] emitted_ff, emitted_in;
   logic [K_BITS-1:0]         ins_cnt_ff, ins_cnt_in;
   logic [K_BITS-1:0]         emit_cnt_ff, emit_cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_INDEX_BITS-1:0] rsp_index_ff, rsp_index_in;
   logic [RSP_DIST_BITS-1:0]  rsp_dist_ff, rsp_dist_in;
   logic [RSP_RANK_BITS-1:0]  rsp_rank_ff, rsp_rank_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                      ram_we;
   logic [SLOT_BITS-1:0]      ram_waddr;
   logic [ENTRY_BITS-1:0]     ram_rdata;
   logic [DIST_BITS-1:0]      rd_dist;
   logic [INDEX_BITS-1:0]     rd_idx;
   logic                      rd_first;
   logic [K_BITS-1:0]         k_last;
   logic                      accept;
   logic                      out_free;
   logic                      is_last;
   logic                      finish;

   knn_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (MAX_NEIGHBOURS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data ({cur_idx_ff, cur_dist_ff}),
      .rd_addr (ptr_ff),
      .rd_data (ram_rdata)
   );

   assign rd_dist  = ram_rdata[DIST_BITS-1:0];
   assign rd_idx   = ram_rdata[ENTRY_BITS-1:DIST_BITS];
   // Read entry orders strictly ahead of the held best entry
   assign rd_first = (rd_dist < best_dist_ff)
                  || (rd_dist == best_dist_ff && rd_idx < best_idx_ff);
   assign k_last   = k - K_BITS'(1);
   assign accept   = empty_found_ff || (cur_dist_ff < best_dist_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign is_last  = (cand_cnt_ff == K_BITS'(1))
                  || (({1'b0, emit_cnt_ff} + (K_BITS+1)'(1)) == {1'b0, ins_cnt_ff});
   assign q_pop    = (state_ff == ST_IDLE) && !q_empty;
   assign ram_we   = (state_ff == ST_DECIDE) && accept;
   assign ram_waddr = empty_found_ff ? empty_slot_ff : best_slot_ff;
   assign finish   = (state_ff == ST_PICK)
                  && ((cand_cnt_ff == '0) || (out_free && is_last));

   always_comb begin
      state_in       = state_ff;
      emit_in        = emit_ff;
      ptr_in         = ptr_ff;
      chk_v_in       = 1'b0;
      chk_slot_in    = ptr_ff;
      cur_dist_in    = cur_dist_ff;
      cur_idx_in     = cur_idx_ff;
      cur_last_in    = cur_last_ff;
      best_dist_in   = best_dist_ff;
      best_idx_in    = best_idx_ff;
      best_slot_in   = best_slot_ff;
      best_v_in      = best_v_ff;
      empty_found_in = empty_found_ff;
      empty_slot_in  = empty_slot_ff;
      cand_cnt_in    = cand_cnt_ff;
      valid_in       = valid_ff;
      emitted_in     = emitted_ff;
      ins_cnt_in     = ins_cnt_ff;
      emit_cnt_in    = emit_cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_index_in   = rsp_index_ff;
      rsp_dist_in    = rsp_dist_ff;
      rsp_rank_in    = rsp_rank_ff;
      rsp_last_in    = rsp_last_ff;

      // Fold the slot read last cycle into the running search
      if (chk_v_ff) begin
         if (!emit_ff) begin
            if (!valid_ff[chk_slot_ff] && !empty_found_ff) begin
               empty_found_in = 1'b1;
               empty_slot_in  = chk_slot_ff;
            end
            if (chk_slot_ff == '0 || !rd_first) begin
               best_dist_in = rd_dist;
               best_idx_in  = rd_idx;
               best_slot_in = chk_slot_ff;
            end
         end else if (valid_ff[chk_slot_ff] && !emitted_ff[chk_slot_ff]) begin
            cand_cnt_in = cand_cnt_ff + 1'b1;
            if (!best_v_ff || rd_first) begin
               best_dist_in = rd_dist;
               best_idx_in  = rd_idx;
               best_slot_in = chk_slot_ff;
               best_v_in    = 1'b1;
            end
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               cur_dist_in    = q_data[DIST_BITS-1:0];
               cur_idx_in     = q_data[ENTRY_BITS-1:DIST_BITS];
               cur_last_in    = q_data[ITEM_BITS-1];
               ptr_in         = '0;
               empty_found_in = 1'b0;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            chk_v_in = 1'b1;
            if (K_BITS'(ptr_ff) == k_last) begin
               state_in = ST_DRAIN;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = emit_ff ? ST_PICK : ST_DECIDE;
         end
         ST_DECIDE: begin
            if (accept) begin
               valid_in[ram_waddr] = 1'b1;
               if (ins_cnt_ff != K_BITS'(MAX_NEIGHBOURS)) begin
                  ins_cnt_in = ins_cnt_ff + 1'b1;
               end
            end
            if (cur_last_ff) begin
               emit_in     = 1'b1;
               emit_cnt_in = '0;
               ptr_in      = '0;
               best_v_in   = 1'b0;
               cand_cnt_in = '0;
               state_in    = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PICK: begin
            if (cand_cnt_ff != '0 && out_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = RSP_INDEX_BITS'(best_idx_ff);
               rsp_dist_in  = (64'(best_dist_ff) > DIST_OUT_MAX)
                            ? RSP_DIST_BITS'(DIST_OUT_MAX)
                            : RSP_DIST_BITS'(best_dist_ff);
               rsp_rank_in  = RSP_RANK_BITS'(emit_cnt_ff);
               rsp_last_in  = is_last;
               emitted_in[best_slot_ff] = 1'b1;
               emit_cnt_in  = emit_cnt_ff + 1'b1;
               ptr_in       = '0;
               best_v_in    = 1'b0;
               cand_cnt_in  = '0;
               state_in     = ST_SCAN;
            end
            if (finish) begin
               valid_in    = '0;
               emitted_in  = '0;
               ins_cnt_in  = '0;
               emit_cnt_in = '0;
               emit_in     = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         emit_ff      <= 1'b0;
         chk_v_ff     <= 1'b0;
         valid_ff     <= '0;
         emitted_ff   <= '0;
         ins_cnt_ff   <= '0;
         emit_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         emit_ff      <= emit_in;
         chk_v_ff     <= chk_v_in;
         valid_ff     <= valid_in;
         emitted_ff   <= emitted_in;
         ins_cnt_ff   <= ins_cnt_in;
         emit_cnt_ff  <= emit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff         <= ptr_in;
      chk_slot_ff    <= chk_slot_in;
      cur_dist_ff    <= cur_dist_in;
      cur_idx_ff     <= cur_idx_in;
      cur_last_ff    <= cur_last_in;
      best_dist_ff   <= best_dist_in;
      best_idx_ff    <= best_idx_in;
      best_slot_ff   <= best_slot_in;
      best_v_ff      <= best_v_in;
      empty_found_ff <= empty_found_in;
      empty_slot_ff  <= empty_slot_in;
      cand_cnt_ff    <= cand_cnt_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_dist_ff    <= rsp_dist_in;
      rsp_rank_ff    <= rsp_rank_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_index = rsp_index_ff;
   assign rsp_dist  = rsp_dist_ff;
   assign rsp_rank  = rsp_rank_ff;
   assign rsp_last  = rsp_last_ff;

   a_emitted_valid: assert property (@(posedge clock) disable iff (reset)
      (emitted_ff & ~valid_ff) == '0)
      else $error("slot marked emitted without a valid entry");

   a_clear_after_search: assert property (@(posedge clock) disable iff (reset)
      finish |=> (valid_ff == '0 && ins_cnt_ff == '0))
      else $error("list not cleared after result emission");

   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      emit_cnt_ff <= ins_cnt_ff)
      else $error("more results emitted than insertions");

endmodule

// ===== rtl/k_nearest_neighbour_select.sv =====
// k-nearest-neighbour selection over a stream of candidate points.
// Program the query point and K through the csr_ write port while the block
// is idle, then stream candidates on req_; mark the final one with tlast.
// Each candidate gets its squared distance in a two-stage pipe and waits in
// a four-entry queue; the selection engine then scans the first K slots of
// the slot memory, one entry per cycle through its single read port, and
// inserts or rejects it, one candidate at a time. Up to four candidates
// can be taken ahead of the engine, so req_tready drops once the pipe and
// the queue together hold four.
// After the final candidate the engine emits the kept entries on rsp_,
// nearest first, with rank and tlast on the final one: each result costs
// one K-slot scan. A search with no entries emits nothing.
// A stalled rsp_tready holds the output register; the engine waits with the
// next result until it is taken, while the front keeps filling the queue.
// Reset empties the list, the queue and the pipe, sets the query to the
// origin and K to 8. The slot memory needs no clearing pass.
module k_nearest_neighbour_select
   import knn_pkg::*;
#(
   parameter int MAX_NEIGHBOURS = MAX_NEIGHBOURS_DEF,
   parameter int COORD_BITS     = COORD_BITS_DEF,
   parameter int INDEX_BITS     = INDEX_BITS_DEF,
   localparam int REQ_FIELD_BITS = 3 * COORD_BITS + INDEX_BITS,
   localparam int REQ_BITS       = ((REQ_FIELD_BITS + 7) / 8) * 8,
   localparam int RSP_FIELD_BITS = RSP_INDEX_BITS + RSP_DIST_BITS + RSP_RANK_BITS,
   localparam int RSP_BITS       = ((RSP_FIELD_BITS + 7) / 8) * 8,
   localparam int CSR_DATA_BITS  = (COORD_BITS > NCOUNT_BITS) ? COORD_BITS : NCOUNT_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   // point_x, point_y, point_z, point_index, zero padding
   input  logic [REQ_BITS-1:0]      req_tdata,
   input  logic                     req_tlast,   // is_last
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // neighbour_index, neighbour_dist_sq, rank, zero padding
   output logic [RSP_BITS-1:0]      rsp_tdata,
   output logic                     rsp_tlast,   // last_result
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int DIST_BITS = 2 * COORD_BITS + 2;
   localparam int ITEM_BITS = DIST_BITS + INDEX_BITS + 1;
   localparam int K_BITS    = $clog2(MAX_NEIGHBOURS + 1);

   logic [COORD_BITS-1:0]     query_x_ff, query_y_ff, query_z_ff;
   logic [NCOUNT_BITS-1:0]    ncount_ff;
   logic [NCOUNT_BITS:0]      ncount_ext;
   logic [K_BITS-1:0]         k_active;

   logic                      q_push, q_pop, q_empty;
   logic [ITEM_BITS-1:0]      q_push_data, q_head;
   logic [QCOUNT_BITS-1:0]    q_count;

   logic [RSP_INDEX_BITS-1:0] rsp_index;
   logic [RSP_DIST_BITS-1:0]  rsp_dist;
   logic [RSP_RANK_BITS-1:0]  rsp_rank;

   // Configuration registers: no read-back; the user writes them only while idle, which the block does not enforce
   always_ff @(posedge clock) begin
      if (reset) begin
         query_x_ff <= '0;
         query_y_ff <= '0;
         query_z_ff <= '0;
         ncount_ff  <= NCOUNT_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_QUERY_X: query_x_ff <= COORD_BITS'(csr_wdata);
            CSR_QUERY_Y: query_y_ff <= COORD_BITS'(csr_wdata);
            CSR_QUERY_Z: query_z_ff <= COORD_BITS'(csr_wdata);
            CSR_NCOUNT:  ncount_ff  <= NCOUNT_BITS'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   // Clamp K: zero acts as one, anything above the slot count as the slot count
   assign ncount_ext = {1'b0, ncount_ff};
   always_comb begin
      if (ncount_ext == '0) begin
         k_active = K_BITS'(1);
      end else if (ncount_ext > (NCOUNT_BITS+1)'(MAX_NEIGHBOURS)) begin
         k_active = K_BITS'(MAX_NEIGHBOURS);
      end else begin
         k_active = K_BITS'(ncount_ext);
      end
   end

   knn_front #(
      .COORD_BITS (COORD_BITS),
      .INDEX_BITS (INDEX_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .pt_x      (req_tdata[COORD_BITS-1:0]),
      .pt_y      (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .pt_z      (req_tdata[3*COORD_BITS-1:2*COORD_BITS]),
      .pt_index  (req_tdata[REQ_FIELD_BITS-1:3*COORD_BITS]),
      .pt_last   (req_tlast),
      .query_x   (query_x_ff),
      .query_y   (query_y_ff),
      .query_z   (query_z_ff),
      .q_count   (q_count),
      .push      (q_push),
      .push_data (q_push_data)
   );

   knn_queue #(
      .WIDTH (ITEM_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .head_data (q_head),
      .empty     (q_empty),
      .count     (q_count)
   );

   knn_back #(
      .MAX_NEIGHBOURS (MAX_NEIGHBOURS),
      .COORD_BITS     (COORD_BITS),
      .INDEX_BITS     (INDEX_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_head),
      .q_pop     (q_pop),
      .k         (k_active),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_index (rsp_index),
      .rsp_dist  (rsp_dist),
      .rsp_rank  (rsp_rank),
      .rsp_last  (rsp_tlast)
   );

   // Pack the result fields, lowest field in the lowest bits
   assign rsp_tdata = RSP_BITS'({rsp_rank, rsp_dist, rsp_index});

endmodule
